>>> rtl/core/lsh_pkg.sv
// shared types, constants and the sharpening arithmetic for the laplacian sharpener
package lsh_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [10:0] RESET_FRAME_WIDTH  = 11'd640;
    localparam logic [15:0] RESET_FRAME_HEIGHT = 16'd480;

    // smallest frame dimension the window handles
    localparam int MIN_DIM = 3;

    // item commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // line buffer banks, one per buffered row
    localparam logic [1:0] BANK_0 = 2'd0;
    localparam logic [1:0] BANK_1 = 2'd1;
    localparam logic [1:0] BANK_2 = 2'd2;

    localparam logic [7:0] PIX_MAX = 8'd255;

    typedef struct packed {
        logic       cmd;
        logic [7:0] blue_in;
        logic [7:0] green_in;
        logic [7:0] red_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
        logic       frame_end;
    } t_out_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // per-item control decided when the item is taken
    typedef struct packed {
        logic       pix;
        logic       compute;
        logic       fire;
        logic       last;
        logic       wr_par;
        logic       rd_par;
        logic [1:0] bank;
    } t_item_ctl;

    // 5*centre minus the four cross neighbours, saturated to 0..255
    function automatic logic [7:0] sharpen_chan(input logic [7:0] c, input logic [7:0] u,
                                                input logic [7:0] l, input logic [7:0] r,
                                                input logic [7:0] d);
        logic signed [11:0] v;
        logic [7:0]         res;
        v = $signed({2'b00, c, 2'b00}) + $signed({4'b0000, c})
            - $signed({4'b0000, u}) - $signed({4'b0000, l})
            - $signed({4'b0000, r}) - $signed({4'b0000, d});
        if (v < 12'sd0) begin
            res = 8'd0;
        end else if (v > $signed({4'b0000, PIX_MAX})) begin
            res = PIX_MAX;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

    function automatic t_rgb sharpen(input t_rgb c, input t_rgb u, input t_rgb l,
                                     input t_rgb r, input t_rgb d);
        t_rgb res;
        res.red   = sharpen_chan(c.red, u.red, l.red, r.red, d.red);
        res.green = sharpen_chan(c.green, u.green, l.green, r.green, d.green);
        res.blue  = sharpen_chan(c.blue, u.blue, l.blue, r.blue, d.blue);
        return res;
    endfunction

endpackage

>>> rtl/core/laplacian_sharpen_3x3_rgb.sv
// top level of the 3x3 laplacian sharpener for streamed rgb frames
//
//   channel   direction  signals                                  payload
//   in        input      i_in_valid / o_in_stall / i_in_data      pixel or flush
//   out       output     o_out_valid / i_out_stall / o_out_data   sharpened pixel
//   cfg       input      i_cfg_we / i_cfg_idx / i_cfg_wdata       frame width, height
//
// one item per clock unless o_in_stall holds it; a result leaves through the line buffer
// read, then the result memory read into the output register
// reset restores a 640x480 frame and the start of a frame; memories are not cleared
// a held result blocks the middle stage, and the input stalls only when that stage
// is occupied and cannot move on
module laplacian_sharpen_3x3_rgb #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  lsh_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output lsh_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_we,
    input  logic [lsh_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lsh_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int CW = $clog2(MAX_WIDTH);

    lsh_pkg::t_item_ctl ctl;
    logic [CW-1:0]      in_col;
    logic [CW-1:0]      wr_col;
    logic [CW-1:0]      rd_col;
    lsh_pkg::t_rgb      pix;
    lsh_pkg::t_rgb      result;
    lsh_pkg::t_rgb      rdata;

    logic               r_s1_valid;
    lsh_pkg::t_item_ctl r_s1_ctl;
    logic [CW-1:0]      r_s1_wr_col;
    logic [CW-1:0]      r_s1_rd_col;
    logic               r_out_valid;
    logic               r_out_last;

    logic adv;
    logic in_take;
    logic s1_go;

    // handshake
    assign adv        = !r_out_valid || !i_out_stall;
    assign in_take    = i_in_valid && (!r_s1_valid || adv);
    assign s1_go      = r_s1_valid && adv;
    assign o_in_stall = r_s1_valid && !adv;

    assign pix.red   = i_in_data.red_in;
    assign pix.green = i_in_data.green_in;
    assign pix.blue  = i_in_data.blue_in;

    lsh_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (in_take),
        .i_cmd       (i_in_data.cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_ctl       (ctl),
        .o_in_col    (in_col),
        .o_wr_col    (wr_col),
        .o_rd_col    (rd_col)
    );

    lsh_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk    (i_clk),
        .i_wr_en  (in_take && ctl.pix),
        .i_bank   (ctl.bank),
        .i_col    (in_col),
        .i_pix    (pix),
        .i_shift  (s1_go && r_s1_ctl.pix),
        .o_result (result)
    );

    lsh_result_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_result_buf (
        .i_clk    (i_clk),
        .i_we     (s1_go && r_s1_ctl.compute),
        .i_wr_par (r_s1_ctl.wr_par),
        .i_wr_col (r_s1_wr_col),
        .i_wdata  (result),
        .i_re     (s1_go && r_s1_ctl.fire),
        .i_rd_par (r_s1_ctl.rd_par),
        .i_rd_col (r_s1_rd_col),
        .o_rdata  (rdata)
    );

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= r_s1_valid && r_s1_ctl.fire;
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_ctl    <= ctl;
            r_s1_wr_col <= wr_col;
            r_s1_rd_col <= rd_col;
        end
        if (s1_go && r_s1_ctl.fire) begin
            r_out_last <= r_s1_ctl.last;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_out_data.blue_out  = rdata.blue;
    assign o_out_data.green_out = rdata.green;
    assign o_out_data.red_out   = rdata.red;
    assign o_out_data.frame_end = r_out_last;

endmodule

>>> rtl/core/lsh_ctrl.sv
// frame geometry registers, raster position counters and per-item control decode
module lsh_ctrl #(
    parameter int MAX_WIDTH = 1024,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_take,
    input  logic                           i_cmd,
    input  logic                           i_cfg_we,
    input  logic [lsh_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lsh_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output lsh_pkg::t_item_ctl             o_ctl,
    output logic [CW-1:0]                  o_in_col,
    output logic [CW-1:0]                  o_wr_col,
    output logic [CW-1:0]                  o_rd_col
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int WX = (WW > 11) ? WW : 11;

    logic [10:0]   r_frame_width, n_frame_width;
    logic [15:0]   r_frame_height, n_frame_height;
    logic [CW-1:0] r_in_col, n_in_col;
    logic [15:0]   r_in_row, n_in_row;
    logic [1:0]    r_bank, n_bank;
    logic [CW-1:0] r_out_col, n_out_col;
    logic [15:0]   r_out_row, n_out_row;
    logic          r_draining, n_draining;

    logic [WX-1:0] width_x;
    logic [WX-1:0] width_eff;
    logic [CW-1:0] wm1;
    logic [CW-1:0] wm2;
    logic [15:0]   hm1;
    logic [15:0]   hm2;

    // effective frame size
    always_comb begin
        width_x = WX'(r_frame_width);
        if (width_x < WX'(lsh_pkg::MIN_DIM)) begin
            width_eff = WX'(lsh_pkg::MIN_DIM);
        end else if (width_x > WX'(MAX_WIDTH)) begin
            width_eff = WX'(MAX_WIDTH);
        end else begin
            width_eff = width_x;
        end
        wm1 = CW'(width_eff - WX'(1));
        wm2 = wm1 - CW'(1);
        if (r_frame_height < 16'(lsh_pkg::MIN_DIM)) begin
            hm1 = 16'(lsh_pkg::MIN_DIM - 1);
        end else begin
            hm1 = r_frame_height - 16'd1;
        end
        hm2 = hm1 - 16'd1;
    end

    // decode of the item at the input
    always_comb begin
        o_ctl.pix     = !r_draining && (i_cmd == lsh_pkg::CMD_PIXEL);
        o_ctl.compute = o_ctl.pix && (r_in_row >= 16'd2) && (r_in_col >= CW'(2));
        o_ctl.fire    = r_draining || (o_ctl.pix && ((r_in_row > 16'd2) ||
                        ((r_in_row == 16'd2) && (r_in_col >= CW'(2)))));
        o_ctl.last    = (r_out_row == hm1) && (r_out_col == wm1);
        o_ctl.wr_par  = ~r_in_row[0];
        o_ctl.bank    = r_bank;
        // window centre clamped to the interior
        if (r_out_row == 16'd0) begin
            o_ctl.rd_par = 1'b1;
        end else if (r_out_row > hm2) begin
            o_ctl.rd_par = hm2[0];
        end else begin
            o_ctl.rd_par = r_out_row[0];
        end
        if (r_out_col == CW'(0)) begin
            o_rd_col = CW'(1);
        end else if (r_out_col > wm2) begin
            o_rd_col = wm2;
        end else begin
            o_rd_col = r_out_col;
        end
        o_in_col = r_in_col;
        o_wr_col = r_in_col - CW'(1);
    end

    // next state of configuration and position counters
    always_comb begin
        n_frame_width  = r_frame_width;
        n_frame_height = r_frame_height;
        n_in_col       = r_in_col;
        n_in_row       = r_in_row;
        n_bank         = r_bank;
        n_out_col      = r_out_col;
        n_out_row      = r_out_row;
        n_draining     = r_draining;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                lsh_pkg::CFG_FRAME_WIDTH:  n_frame_width  = i_cfg_wdata[10:0];
                lsh_pkg::CFG_FRAME_HEIGHT: n_frame_height = i_cfg_wdata;
                default: ;
            endcase
            n_in_col   = '0;
            n_in_row   = '0;
            n_bank     = lsh_pkg::BANK_0;
            n_out_col  = '0;
            n_out_row  = '0;
            n_draining = 1'b0;
        end else if (i_take) begin
            // input raster position
            if (o_ctl.pix) begin
                if (r_in_col == wm1) begin
                    n_in_col = '0;
                    if (r_in_row == hm1) begin
                        n_in_row   = '0;
                        n_bank     = lsh_pkg::BANK_0;
                        n_draining = 1'b1;
                    end else begin
                        n_in_row = r_in_row + 16'd1;
                        case (r_bank)
                            lsh_pkg::BANK_0: n_bank = lsh_pkg::BANK_1;
                            lsh_pkg::BANK_1: n_bank = lsh_pkg::BANK_2;
                            default:         n_bank = lsh_pkg::BANK_0;
                        endcase
                    end
                end else begin
                    n_in_col = r_in_col + CW'(1);
                end
            end
            // output raster position
            if (o_ctl.fire) begin
                if (o_ctl.last) begin
                    n_out_col  = '0;
                    n_out_row  = '0;
                    n_draining = 1'b0;
                end else if (r_out_col == wm1) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + 16'd1;
                end else begin
                    n_out_col = r_out_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= lsh_pkg::RESET_FRAME_WIDTH;
            r_frame_height <= lsh_pkg::RESET_FRAME_HEIGHT;
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_bank         <= lsh_pkg::BANK_0;
            r_out_col      <= '0;
            r_out_row      <= '0;
            r_draining     <= 1'b0;
        end else begin
            r_frame_width  <= n_frame_width;
            r_frame_height <= n_frame_height;
            r_in_col       <= n_in_col;
            r_in_row       <= n_in_row;
            r_bank         <= n_bank;
            r_out_col      <= n_out_col;
            r_out_row      <= n_out_row;
            r_draining     <= n_draining;
        end
    end

endmodule

>>> rtl/core/lsh_line_buf.sv
// three-row line buffer memory, 3x3 cross window and sharpening datapath
module lsh_line_buf #(
    parameter int MAX_WIDTH = 1024,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int AW = $clog2(3 * MAX_WIDTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [1:0]    i_bank,
    input  logic [CW-1:0] i_col,
    input  lsh_pkg::t_rgb i_pix,
    input  logic          i_shift,
    output lsh_pkg::t_rgb o_result
);

    lsh_pkg::t_rgb r_mem [0:3*MAX_WIDTH-1];

    lsh_pkg::t_rgb r_rd_up1;
    lsh_pkg::t_rgb r_rd_up2;
    lsh_pkg::t_rgb r_pix;
    lsh_pkg::t_rgb r_win1_m1;
    lsh_pkg::t_rgb r_win1_m2;
    lsh_pkg::t_rgb r_win2_m1;
    lsh_pkg::t_rgb r_win0_m1;

    logic [1:0]    bank_up1;
    logic [1:0]    bank_up2;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] up1_addr;
    logic [AW-1:0] up2_addr;

    function automatic logic [AW-1:0] bank_addr(input logic [1:0] bank,
                                                input logic [CW-1:0] col);
        logic [AW-1:0] base;
        case (bank)
            lsh_pkg::BANK_0: base = '0;
            lsh_pkg::BANK_1: base = AW'(MAX_WIDTH);
            lsh_pkg::BANK_2: base = AW'(2 * MAX_WIDTH);
            default:         base = '0;
        endcase
        return base + AW'(col);
    endfunction

    // banks of the two rows above the incoming one
    always_comb begin
        case (i_bank)
            lsh_pkg::BANK_0: begin
                bank_up1 = lsh_pkg::BANK_2;
                bank_up2 = lsh_pkg::BANK_1;
            end
            lsh_pkg::BANK_1: begin
                bank_up1 = lsh_pkg::BANK_0;
                bank_up2 = lsh_pkg::BANK_2;
            end
            default: begin
                bank_up1 = lsh_pkg::BANK_1;
                bank_up2 = lsh_pkg::BANK_0;
            end
        endcase
        wr_addr  = bank_addr(i_bank, i_col);
        up1_addr = bank_addr(bank_up1, i_col);
        up2_addr = bank_addr(bank_up2, i_col);
    end

    // store the new pixel, fetch the same column of the two rows above
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[wr_addr] <= i_pix;
            r_rd_up1       <= r_mem[up1_addr];
            r_rd_up2       <= r_mem[up2_addr];
            r_pix          <= i_pix;
        end
    end

    // slide the window one column on each pixel
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_win1_m2 <= r_win1_m1;
            r_win1_m1 <= r_rd_up1;
            r_win2_m1 <= r_rd_up2;
            r_win0_m1 <= r_pix;
        end
    end

    // centre is the previous column of the middle row
    assign o_result = lsh_pkg::sharpen(r_win1_m1, r_win2_m1, r_win1_m2, r_rd_up1, r_win0_m1);

endmodule

>>> rtl/core/lsh_result_buf.sv
// two-row result memory with same-cycle write forwarding into the output register
module lsh_result_buf #(
    parameter int MAX_WIDTH = 1024,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(2 * MAX_WIDTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic          i_wr_par,
    input  logic [CW-1:0] i_wr_col,
    input  lsh_pkg::t_rgb i_wdata,
    input  logic          i_re,
    input  logic          i_rd_par,
    input  logic [CW-1:0] i_rd_col,
    output lsh_pkg::t_rgb o_rdata
);

    lsh_pkg::t_rgb r_mem [0:2*MAX_WIDTH-1];

    lsh_pkg::t_rgb r_rd_data;
    lsh_pkg::t_rgb r_fwd_data;
    logic          r_fwd_hit;

    logic [RW-1:0] wr_addr;
    logic [RW-1:0] rd_addr;
    logic          hit;

    always_comb begin
        wr_addr = i_wr_par ? RW'(MAX_WIDTH) + RW'(i_wr_col) : RW'(i_wr_col);
        rd_addr = i_rd_par ? RW'(MAX_WIDTH) + RW'(i_rd_col) : RW'(i_rd_col);
        hit     = i_we && (wr_addr == rd_addr);
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[wr_addr] <= i_wdata;
        end
    end

    // read port holds its data while the result waits downstream
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_data  <= r_mem[rd_addr];
            r_fwd_data <= i_wdata;
            r_fwd_hit  <= hit;
        end
    end

    assign o_rdata = r_fwd_hit ? r_fwd_data : r_rd_data;

endmodule

>>> bench/laplacian_sharpen_3x3_rgb_tb.sv
// self-checking bench for the streamed 3x3 laplacian sharpener with its own pixel predictor
module laplacian_sharpen_3x3_rgb_tb;

    localparam int MAX_W           = 1024;
    localparam int RANDOM_ITEMS    = 900;
    localparam int WATCHDOG_CYCLES = 5000;

    // predicted sharpened frame and the queue of pixels still owed by the block
    class sharpen_scoreboard;
        lsh_pkg::t_rgb      pix_rows[3*MAX_W];
        lsh_pkg::t_rgb      sharp_rows[2*MAX_W];
        logic [10:0]        frame_w;
        logic [15:0]        frame_h;
        int                 in_col;
        int                 in_row;
        int                 out_col;
        int                 out_row;
        bit                 draining;
        lsh_pkg::t_out_item expected_pixels[$];
        int                 mismatches;
        int                 results_seen;
        int                 frames_done;
        int                 reg_writes;

        function new();
            foreach (pix_rows[i]) pix_rows[i] = '0;
            foreach (sharp_rows[i]) sharp_rows[i] = '0;
            frame_w = lsh_pkg::RESET_FRAME_WIDTH;
            frame_h = lsh_pkg::RESET_FRAME_HEIGHT;
            restart();
        endfunction

        function void restart();
            in_col   = 0;
            in_row   = 0;
            out_col  = 0;
            out_row  = 0;
            draining = 1'b0;
        endfunction

        function int eff_w();
            if (frame_w < lsh_pkg::MIN_DIM) return lsh_pkg::MIN_DIM;
            if (frame_w > MAX_W) return MAX_W;
            return frame_w;
        endfunction

        function int eff_h();
            if (frame_h < lsh_pkg::MIN_DIM) return lsh_pkg::MIN_DIM;
            return frame_h;
        endfunction

        // register write: new geometry applies at once and the frame starts over
        function void write_reg(logic [lsh_pkg::CFG_IDX_W-1:0] idx,
                                logic [lsh_pkg::CFG_DATA_W-1:0] data);
            if (idx == lsh_pkg::CFG_FRAME_WIDTH) begin
                frame_w = data[10:0];
            end else if (idx == lsh_pkg::CFG_FRAME_HEIGHT) begin
                frame_h = data[15:0];
            end else begin
                return;
            end
            reg_writes++;
            restart();
        endfunction

        function logic [7:0] sharp_chan(int c, int u, int l, int r, int d);
            int v;
            v = 5*c - u - l - r - d;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            return 8'(v);
        endfunction

        function lsh_pkg::t_rgb sharp_px(lsh_pkg::t_rgb c, lsh_pkg::t_rgb u, lsh_pkg::t_rgb l,
                                         lsh_pkg::t_rgb r, lsh_pkg::t_rgb d);
            lsh_pkg::t_rgb res;
            res.red   = sharp_chan(c.red, u.red, l.red, r.red, d.red);
            res.green = sharp_chan(c.green, u.green, l.green, r.green, d.green);
            res.blue  = sharp_chan(c.blue, u.blue, l.blue, r.blue, d.blue);
            return res;
        endfunction

        // next raster result, window centre held inside the frame border
        function void owe_pixel();
            int                 w;
            int                 h;
            int                 cr;
            int                 cc;
            bit                 last;
            lsh_pkg::t_rgb      v;
            lsh_pkg::t_out_item o;
            w    = eff_w();
            h    = eff_h();
            cr   = out_row;
            cc   = out_col;
            last = (out_row >= h - 1) && (out_col >= w - 1);
            if (cr < 1) cr = 1;
            if (cr > h - 2) cr = h - 2;
            if (cc < 1) cc = 1;
            if (cc > w - 2) cc = w - 2;
            v = sharp_rows[(cr & 1)*MAX_W + cc];
            o.blue_out  = v.blue;
            o.green_out = v.green;
            o.red_out   = v.red;
            o.frame_end = last;
            expected_pixels.push_back(o);
            if (last) begin
                restart();
            end else if (out_col + 1 >= w) begin
                out_col = 0;
                out_row++;
            end else begin
                out_col++;
            end
        endfunction

        // accepted input transfer; returns 0 when the block just ignores it
        function bit take_item(lsh_pkg::t_in_item it);
            int            w;
            int            h;
            int            c;
            int            up_row;
            int            mid_row;
            int            cur_row;
            bit            fire;
            lsh_pkg::t_rgb p;
            w = eff_w();
            h = eff_h();
            if (draining) begin
                owe_pixel();
                return 1'b1;
            end
            if (it.cmd == lsh_pkg::CMD_FLUSH) return 1'b0;
            p.red   = it.red_in;
            p.green = it.green_in;
            p.blue  = it.blue_in;
            pix_rows[(in_row % 3)*MAX_W + in_col] = p;
            // window complete once two rows and two columns are in
            if (in_row >= 2 && in_col >= 2) begin
                up_row  = ((in_row + 1) % 3)*MAX_W;
                mid_row = ((in_row + 2) % 3)*MAX_W;
                cur_row = (in_row % 3)*MAX_W;
                c       = in_col - 1;
                sharp_rows[((in_row - 1) & 1)*MAX_W + c] =
                    sharp_px(pix_rows[mid_row + c], pix_rows[up_row + c],
                             pix_rows[mid_row + c - 1], pix_rows[mid_row + c + 1],
                             pix_rows[cur_row + c]);
            end
            fire = (in_row > 2) || (in_row == 2 && in_col >= 2);
            if (in_col + 1 >= w) begin
                in_col = 0;
                if (in_row + 1 >= h) begin
                    in_row   = 0;
                    draining = 1'b1;
                end else begin
                    in_row++;
                end
            end else begin
                in_col++;
            end
            if (fire) owe_pixel();
            return 1'b1;
        endfunction

        function void flag(string what, lsh_pkg::t_out_item want, lsh_pkg::t_out_item got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s: expected b=%0d g=%0d r=%0d end=%0d, got b=%0d g=%0d r=%0d end=%0d",
                         what, want.blue_out, want.green_out, want.red_out, want.frame_end,
                         got.blue_out, got.green_out, got.red_out, got.frame_end);
            end
        endfunction

        // accepted output transfer against the oldest owed pixel
        function void check_pixel(lsh_pkg::t_out_item got);
            lsh_pkg::t_out_item want;
            results_seen++;
            if (got.frame_end) frames_done++;
            if (expected_pixels.size() == 0) begin
                flag("unexpected result", '0, got);
                return;
            end
            want = expected_pixels.pop_front();
            if (got.blue_out !== want.blue_out || got.green_out !== want.green_out ||
                got.red_out !== want.red_out || got.frame_end !== want.frame_end) begin
                flag("pixel mismatch", want, got);
            end
        endfunction
    endclass

    logic                           i_clk     = 1'b0;
    logic                           i_rst_n   = 1'b0;
    logic                           in_valid  = 1'b0;
    lsh_pkg::t_in_item              in_data   = '0;
    logic                           out_stall = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [lsh_pkg::CFG_IDX_W-1:0]  cfg_idx   = lsh_pkg::CFG_FRAME_WIDTH;
    logic [lsh_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           in_stall;
    logic                           out_valid;
    lsh_pkg::t_out_item             out_data;

    sharpen_scoreboard sb;
    int taken_items = 0;
    int gap_rate    = 0;
    int stall_rate  = 0;
    int stall_left  = 0;
    int idle_cycles = 0;
    bit quiet       = 1'b0;

    laplacian_sharpen_3x3_rgb #(.MAX_WIDTH(MAX_W)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // receiver stalls in random bursts
    always @(negedge i_clk) begin
        if (quiet || stall_rate == 0) begin
            stall_left = 0;
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < stall_rate) begin
            stall_left = $urandom_range(0, 10);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // result check and watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_valid && !out_stall) sb.check_pixel(out_data);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("watchdog: %0d cycles without a transfer", idle_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 7))
            0: begin
                return 8'd0;
            end
            1: begin
                return 8'd255;
            end
            default: begin
                return 8'($urandom);
            end
        endcase
    endfunction

    function automatic lsh_pkg::t_in_item mk_item(logic cmd, logic [7:0] r, logic [7:0] g,
                                                  logic [7:0] b);
        lsh_pkg::t_in_item it;
        it.cmd      = cmd;
        it.red_in   = r;
        it.green_in = g;
        it.blue_in  = b;
        return it;
    endfunction

    function automatic lsh_pkg::t_in_item rand_pixel();
        return mk_item(lsh_pkg::CMD_PIXEL, pick_level(), pick_level(), pick_level());
    endfunction

    function automatic lsh_pkg::t_in_item rand_flush();
        return mk_item(lsh_pkg::CMD_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    task automatic idle_sender(input int n);
        repeat (n) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
    endtask

    // one input transfer, with an occasional gap ahead of it
    task automatic send_item(input lsh_pkg::t_in_item it);
        if (!quiet && gap_rate != 0 && $urandom_range(0, 99) < gap_rate) begin
            idle_sender($urandom_range(1, 11));
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        taken_items += sb.take_item(it);
    endtask

    // sender holds off until every owed pixel is out and the pipe is quiet
    task automatic wait_idle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [lsh_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lsh_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // one frame in raster order, optionally cut short, then the drain
    task automatic run_frame(input bit noise, input bit broken);
        int total;
        int stop_at;
        total   = sb.eff_w() * sb.eff_h();
        stop_at = broken ? $urandom_range(1, total - 1) : total;
        for (int n = 0; n < stop_at; n++) begin
            if (noise && $urandom_range(0, 11) == 0) send_item(rand_flush());
            send_item(rand_pixel());
        end
        while (sb.draining) begin
            if (noise && $urandom_range(0, 5) == 0) begin
                send_item(rand_pixel());
            end else begin
                send_item(rand_flush());
            end
        end
    endtask

    initial begin
        logic [7:0]  dir_red[9];
        logic [7:0]  dir_green[9];
        logic [7:0]  dir_blue[9];
        logic [15:0] wdata;
        int          base;
        int          w_val;
        bit          broken;
        sb = new();
        dir_red   = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
        dir_green = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0};
        dir_blue  = '{8'd7, 8'd90, 8'd200, 8'd100, 8'd100, 8'd110, 8'd13, 8'd95, 8'd250};
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: enough of a 640 wide frame to get the first results out
        gap_rate   = 10;
        stall_rate = 10;
        repeat (2*640 + 10) send_item(rand_pixel());
        wait_idle();

        // smallest frame: both saturation ends and a mid value, ignored flush first
        cfg_write(lsh_pkg::CFG_FRAME_WIDTH, 16'd3);
        cfg_write(lsh_pkg::CFG_FRAME_HEIGHT, 16'd3);
        send_item(rand_flush());
        for (int i = 0; i < 9; i++) send_item(mk_item(lsh_pkg::CMD_PIXEL, dir_red[i],
                                                      dir_green[i], dir_blue[i]));
        send_item(mk_item(lsh_pkg::CMD_PIXEL, 8'd255, 8'd255, 8'd255));
        while (sb.draining) send_item(rand_flush());
        wait_idle();

        // undersized registers, junk above the width field
        cfg_write(lsh_pkg::CFG_FRAME_WIDTH, 16'hF801);
        cfg_write(lsh_pkg::CFG_FRAME_HEIGHT, 16'd0);
        run_frame(1'b1, 1'b0);
        wait_idle();

        // widest frame, width register past the maximum
        cfg_write(lsh_pkg::CFG_FRAME_WIDTH, 16'hFFFF);
        cfg_write(lsh_pkg::CFG_FRAME_HEIGHT, 16'd2);
        run_frame(1'b1, 1'b0);
        wait_idle();

        // tallest frame, only its top rows
        cfg_write(lsh_pkg::CFG_FRAME_WIDTH, 16'd3);
        cfg_write(lsh_pkg::CFG_FRAME_HEIGHT, 16'hFFFF);
        repeat (40) send_item(rand_pixel());
        wait_idle();

        // random geometries, frames back to back, some cut short
        base   = taken_items;
        broken = 1'b1;
        while (taken_items - base < RANDOM_ITEMS) begin
            quiet = (taken_items - base) > (RANDOM_ITEMS*3)/4;
            gap_rate   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
            stall_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
            if (broken || $urandom_range(0, 2) != 0) begin
                wait_idle();
                case ($urandom_range(0, 9))
                    0: begin
                        w_val = $urandom_range(0, 2);
                    end
                    1: begin
                        w_val = $urandom_range(13, 48);
                    end
                    default: begin
                        w_val = $urandom_range(3, 12);
                    end
                endcase
                wdata = 16'(w_val);
                if ($urandom_range(0, 5) == 0) wdata[15:11] = 5'($urandom);
                if (broken || $urandom_range(0, 3) != 0) begin
                    cfg_write(lsh_pkg::CFG_FRAME_WIDTH, wdata);
                end
                wdata = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 2))
                                                    : 16'($urandom_range(3, 8));
                // the tall frame above must never carry over into this loop
                if (broken || $urandom_range(0, 3) != 0) begin
                    cfg_write(lsh_pkg::CFG_FRAME_HEIGHT, wdata);
                end
            end
            broken = !quiet && $urandom_range(0, 5) == 0;
            run_frame($urandom_range(0, 1), broken);
        end

        quiet = 1'b1;
        wait_idle();
        $display("covered %0d counted input transfers, %0d checked results, %0d frame ends",
                 taken_items, sb.results_seen, sb.frames_done);
        $display("%0d register writes over widths 3 to %0d and heights 3 to 65535, with stalls",
                 sb.reg_writes, MAX_W);
        if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
